[hdl/gpab_pkg.sv]
`default_nettype none

package gpab_pkg;

    // framebuffer address width, at most 32
    localparam int ADDRESS_BITS = 20;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;

    localparam int COORD_W = 11;
    localparam int DIM_W   = 10;
    localparam int COV_W   = 8;
    localparam int RGB_W   = 16;
    localparam int CH_W    = 8;
    localparam int PROD_W  = 2 * DIM_W;

    localparam logic [COV_W-1:0]  COV_FULL   = 8'd255;
    localparam logic [16:0]       ROUND_BIAS = 17'd127;
    localparam logic [23:0]       DIV_HALF   = 24'd128;

    localparam logic [RGB_W-1:0] INK_RGB_RST      = 16'd0;
    localparam logic [DIM_W-1:0] SCREEN_WIDTH_RST = 10'd400;
    localparam logic [DIM_W-1:0] Y_LIMIT_RST      = 10'd240;
    localparam logic [DIM_W-1:0] RIGHT_EDGE_RST   = 10'd400;
    localparam logic [DIM_W-1:0] ROW_STRIDE_RST   = 10'd240;

    typedef enum logic [2:0] {
        REG_INK_RGB      = 3'd0,
        REG_SCREEN_WIDTH = 3'd1,
        REG_Y_LIMIT      = 3'd2,
        REG_RIGHT_EDGE   = 3'd3,
        REG_ROW_STRIDE   = 3'd4
    } gpab_reg_t;

    typedef struct packed {
        logic [RGB_W-1:0] ink_rgb;
        logic [DIM_W-1:0] screen_width;
        logic [DIM_W-1:0] y_limit;
        logic [DIM_W-1:0] right_edge;
        logic [DIM_W-1:0] row_stride;
    } gpab_cfg_t;

    // per-stage load enables for the colour lanes
    typedef struct packed {
        logic take2;
        logic take3;
        logic take4;
    } gpab_adv_t;

    function automatic logic [CH_W-1:0] widen5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [CH_W-1:0] widen6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

endpackage

`default_nettype wire

[hdl/gpab_if.sv]
`default_nettype none

interface gpab_in_if;
    import gpab_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [COV_W-1:0]          coverage;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [RGB_W-1:0]          background;

    modport source (output valid, coverage, pos_x, pos_y, background, input ready);
    modport sink (input valid, coverage, pos_x, pos_y, background, output ready);
endinterface

interface gpab_out_if;
    import gpab_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    write_enable;
    logic [ADDRESS_BITS-1:0] address;
    logic [RGB_W-1:0]        pixel;

    modport source (output valid, write_enable, address, pixel, input ready);
    modport sink (input valid, write_enable, address, pixel, output ready);
endinterface

`default_nettype wire

[hdl/glyph_pixel_alpha_blend_core.sv]
// glyph pixel alpha blend
// pix_in carries one glyph word: coverage, signed column and row, and the
// rgb565 background under it. pix_out returns one word for each: a write
// flag, the framebuffer address (row * row_stride + column) and the blended
// rgb565 pixel. skipped pixels give write_enable 0 with address and pixel 0.
// the apb port holds ink_rgb, screen_width, y_limit, right_edge and
// row_stride at byte addresses 0, 4, 8, 12 and 16; pready is always high.
// four register stages: clip test and colour widening, the 8x8 channel
// products and the 10x10 address product, the channel sums and address add,
// then the divide by 255 into the output register, with the rgb565 repack after it.
// a word taken into stage 1 moves through stages 2 and 3 and is offered on
// pix_out from stage 4; one word per cycle while ready stays high.
// each stage holds its own valid bit and loads whenever it is empty or its
// successor loads, so a stalled output still lets bubbles close up behind it;
// pix_in.ready falls only once all four stages are full and the output stalls.
// reset empties the pipeline and loads the register reset values.
`default_nettype none

module glyph_pixel_alpha_blend_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [gpab_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [gpab_pkg::APB_DATA_W-1:0] pwdata,
    output      logic [gpab_pkg::APB_DATA_W-1:0] prdata,
    output      logic                            pready,
    gpab_in_if.sink                              pix_in,
    gpab_out_if.source                           pix_out
);
    import gpab_pkg::*;

    gpab_cfg_t cfg;
    gpab_adv_t adv;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic take1, take2, take3, take4;

    logic             ok1_reg, ok2_reg, ok3_reg, ok4_reg;
    logic             ok1_next;
    logic [COV_W-1:0] cov1_reg;
    logic [CH_W-1:0]  fr1_reg, fg1_reg, fb1_reg;
    logic [CH_W-1:0]  br1_reg, bg1_reg, bb1_reg;
    logic [DIM_W-1:0] x1_reg, y1_reg, x2_reg;
    logic [PROD_W-1:0] prod2_reg;
    logic [ADDRESS_BITS-1:0] addr3_reg, addr3_next, addr4_reg;
    logic [CH_W-1:0]  r4, g4, b4;
    logic [DIM_W-1:0] px, py;

    gpab_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // a stage loads when empty or when the one after it loads
    assign take4 = !v4_reg || pix_out.ready;
    assign take3 = !v3_reg || take4;
    assign take2 = !v2_reg || take3;
    assign take1 = !v1_reg || take2;
    assign pix_in.ready = take1;

    assign adv.take2 = take2;
    assign adv.take3 = take3;
    assign adv.take4 = take4;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (take1)
            begin
                v1_reg <= pix_in.valid;
            end
            if (take2)
            begin
                v2_reg <= v1_reg;
            end
            if (take3)
            begin
                v3_reg <= v2_reg;
            end
            if (take4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // stage 1: clip test and colour widening
    assign px = pix_in.pos_x[DIM_W-1:0];
    assign py = pix_in.pos_y[DIM_W-1:0];

    assign ok1_next = (pix_in.coverage != '0)
                   && !pix_in.pos_x[COORD_W-1] && !pix_in.pos_y[COORD_W-1]
                   && (py < cfg.y_limit)
                   && (px < cfg.screen_width)
                   && (px < cfg.right_edge);

    always_ff @(posedge clk)
    begin
        if (take1)
        begin
            ok1_reg  <= ok1_next;
            cov1_reg <= pix_in.coverage;
            x1_reg   <= px;
            y1_reg   <= py;
            fr1_reg  <= widen5(cfg.ink_rgb[15:11]);
            fg1_reg  <= widen6(cfg.ink_rgb[10:5]);
            fb1_reg  <= widen5(cfg.ink_rgb[4:0]);
            br1_reg  <= widen5(pix_in.background[15:11]);
            bg1_reg  <= widen6(pix_in.background[10:5]);
            bb1_reg  <= widen5(pix_in.background[4:0]);
        end
        if (take2)
        begin
            ok2_reg   <= ok1_reg;
            x2_reg    <= x1_reg;
            prod2_reg <= PROD_W'(y1_reg) * PROD_W'(cfg.row_stride);
        end
        if (take3)
        begin
            ok3_reg   <= ok2_reg;
            addr3_reg <= addr3_next;
        end
        if (take4)
        begin
            ok4_reg   <= ok3_reg;
            addr4_reg <= ok3_reg ? addr3_reg : '0;
        end
    end

    assign addr3_next = ADDRESS_BITS'(21'(prod2_reg) + 21'(x2_reg));

    gpab_chan u_chan_r (
        .clk   (clk),
        .adv   (adv),
        .cov   (cov1_reg),
        .fg    (fr1_reg),
        .bg    (br1_reg),
        .mixed (r4)
    );

    gpab_chan u_chan_g (
        .clk   (clk),
        .adv   (adv),
        .cov   (cov1_reg),
        .fg    (fg1_reg),
        .bg    (bg1_reg),
        .mixed (g4)
    );

    gpab_chan u_chan_b (
        .clk   (clk),
        .adv   (adv),
        .cov   (cov1_reg),
        .fg    (fb1_reg),
        .bg    (bb1_reg),
        .mixed (b4)
    );

    assign pix_out.valid        = v4_reg;
    assign pix_out.write_enable = ok4_reg;
    assign pix_out.address      = addr4_reg;
    assign pix_out.pixel        = ok4_reg ? {r4[7:3], g4[7:2], b4[7:3]} : '0;

`ifndef SYNTHESIS
    // input back-pressure only once every stage holds a word
    assert property (@(posedge clk) disable iff (!rst_n)
        !pix_in.ready |-> (v1_reg && v2_reg && v3_reg && v4_reg && !pix_out.ready))
        else $error("input stalled with a bubble in the pipeline");

    // skipped pixels carry zero address and pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        (pix_out.valid && !pix_out.write_enable) |->
            (pix_out.address == '0 && pix_out.pixel == '0))
        else $error("skipped word carries non-zero fields");

    // a full pipeline with a taking receiver keeps accepting
    assert property (@(posedge clk) disable iff (!rst_n)
        pix_out.ready |-> pix_in.ready)
        else $error("input stalled while output drains");
`endif

endmodule

`default_nettype wire

[hdl/gpab_cfg.sv]
`default_nettype none

module gpab_cfg (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [gpab_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [gpab_pkg::APB_DATA_W-1:0] pwdata,
    output      logic [gpab_pkg::APB_DATA_W-1:0] prdata,
    output      logic                            pready,
    output      gpab_pkg::gpab_cfg_t             cfg
);
    import gpab_pkg::*;

    gpab_cfg_t cfg_reg;
    gpab_reg_t sel;
    logic      wr;

    assign sel    = gpab_reg_t'(paddr[APB_ADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ink_rgb      <= INK_RGB_RST;
            cfg_reg.screen_width <= SCREEN_WIDTH_RST;
            cfg_reg.y_limit      <= Y_LIMIT_RST;
            cfg_reg.right_edge   <= RIGHT_EDGE_RST;
            cfg_reg.row_stride   <= ROW_STRIDE_RST;
        end
        else if (wr)
        begin
            case (sel)
                REG_INK_RGB:      cfg_reg.ink_rgb      <= pwdata[RGB_W-1:0];
                REG_SCREEN_WIDTH: cfg_reg.screen_width <= pwdata[DIM_W-1:0];
                REG_Y_LIMIT:      cfg_reg.y_limit      <= pwdata[DIM_W-1:0];
                REG_RIGHT_EDGE:   cfg_reg.right_edge   <= pwdata[DIM_W-1:0];
                REG_ROW_STRIDE:   cfg_reg.row_stride   <= pwdata[DIM_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            REG_INK_RGB:      prdata = APB_DATA_W'(cfg_reg.ink_rgb);
            REG_SCREEN_WIDTH: prdata = APB_DATA_W'(cfg_reg.screen_width);
            REG_Y_LIMIT:      prdata = APB_DATA_W'(cfg_reg.y_limit);
            REG_RIGHT_EDGE:   prdata = APB_DATA_W'(cfg_reg.right_edge);
            REG_ROW_STRIDE:   prdata = APB_DATA_W'(cfg_reg.row_stride);
            default:          prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[hdl/gpab_chan.sv]
`default_nettype none

module gpab_chan (
    input  wire logic                      clk,
    input  wire gpab_pkg::gpab_adv_t       adv,
    input  wire logic [gpab_pkg::COV_W-1:0] cov,
    input  wire logic [gpab_pkg::CH_W-1:0]  fg,
    input  wire logic [gpab_pkg::CH_W-1:0]  bg,
    output      logic [gpab_pkg::CH_W-1:0]  mixed
);
    import gpab_pkg::*;

    logic [15:0]     pf_reg;
    logic [15:0]     pb_reg;
    logic [15:0]     sum_reg;
    logic [CH_W-1:0] res_reg;
    logic [COV_W-1:0] inv_cov;
    logic [15:0]     sum_next;
    logic [23:0]     div_sum;

    assign inv_cov = COV_FULL - cov;

    // sum of both products plus bias stays below 2^16
    assign sum_next = 16'(17'(pf_reg) + 17'(pb_reg) + ROUND_BIAS);

    // x*257 as x<<8 plus x, then round and keep bits 23:16
    assign div_sum = {sum_reg, 8'h00} + 24'(sum_reg) + DIV_HALF;

    always_ff @(posedge clk)
    begin
        if (adv.take2)
        begin
            pf_reg <= 16'(fg) * 16'(cov);
            pb_reg <= 16'(bg) * 16'(inv_cov);
        end
        if (adv.take3)
        begin
            sum_reg <= sum_next;
        end
        if (adv.take4)
        begin
            res_reg <= div_sum[23:16];
        end
    end

    assign mixed = res_reg;

endmodule

`default_nettype wire
